>>> hdl/two_channel_note_sequencer_unit_macros.svh
// Assertion macros used by the note sequencer back end.
`ifndef TWO_CHANNEL_NOTE_SEQUENCER_UNIT_MACROS_SVH
`define TWO_CHANNEL_NOTE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCNS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcns assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCNS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcns assertion failed");

`endif

>>> hdl/tcns_pkg.sv
// Shared types, codes and constants of the note sequencer.
package tcns_pkg;

	// Defaults for the top-level parameters
	localparam int TABLE_DEPTH_DEF  = 64;
	localparam int NUM_CHANNELS_DEF = 2;

	// Field widths fixed by the stream format
	localparam int INDEX_W = 6;
	localparam int NOTE_W  = 16;
	localparam int DUR_W   = 16;
	localparam int COUNT_W = 7;
	localparam int ENTRY_W = NOTE_W + DUR_W;
	localparam int S_DATA_W = 48;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 40;

	// Command queue between front and back; depth is a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Function codes as carried on tuser
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_START = 2'd2,
		FUNC_STOP  = 2'd3
	} func_t;

	// Classified operations; ignored items become OP_NOP
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_WRITE,
		OP_START,
		OP_STOP
	} op_t;

	// One classified command, count already clipped to the table depth
	typedef struct packed {
		op_t                  op;
		logic                 ch;
		logic [INDEX_W-1:0]   idx;
		logic [NOTE_W-1:0]    note;
		logic [DUR_W-1:0]     dur;
		logic [COUNT_W-1:0]   cnt;
		logic                 loop_en;
	} cmd_t;

	// Per-channel report, tone in the low bits
	typedef struct packed {
		logic              busy;
		logic              changed;
		logic              silent;
		logic [NOTE_W-1:0] tone;
	} rpt_t;

endpackage

>>> hdl/tcns_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tcns_front.sv
// Front end: accepts input transactions and classifies them into commands.
module tcns_front #(
	parameter int TABLE_DEPTH  = tcns_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_CHANNELS = tcns_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tcns_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [tcns_pkg::S_USER_W-1:0] s_tuser,
	input  logic                          q_full,
	output logic                          q_push,
	output tcns_pkg::cmd_t                q_cmd
);

	tcns_pkg::func_t                func;
	logic                           ch;
	logic [tcns_pkg::INDEX_W-1:0]   idx;
	logic [tcns_pkg::COUNT_W-1:0]   cnt;
	logic                           ch_ok;
	logic                           idx_ok;
	logic [tcns_pkg::COUNT_W-1:0]   cnt_clip;

	// Unpack the transaction
	assign func = tcns_pkg::func_t'(s_tuser);
	assign ch   = s_tdata[0];
	assign idx  = s_tdata[6:1];
	assign cnt  = s_tdata[45:39];

	// Range checks and count clipping
	assign ch_ok    = (32'(ch) < 32'(NUM_CHANNELS));
	assign idx_ok   = (32'(idx) < 32'(TABLE_DEPTH));
	assign cnt_clip = (32'(cnt) > 32'(TABLE_DEPTH)) ? tcns_pkg::COUNT_W'(TABLE_DEPTH) : cnt;

	// Accept whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	// Classify; items that change nothing become no-ops
	always_comb begin
		q_cmd.ch      = ch;
		q_cmd.idx     = idx;
		q_cmd.note    = s_tdata[22:7];
		q_cmd.dur     = s_tdata[38:23];
		q_cmd.cnt     = cnt_clip;
		q_cmd.loop_en = s_tdata[46];
		unique case (func)
			tcns_pkg::FUNC_TICK: begin
				q_cmd.op = tcns_pkg::OP_TICK;
			end
			tcns_pkg::FUNC_WRITE: begin
				q_cmd.op = (ch_ok && idx_ok) ? tcns_pkg::OP_WRITE : tcns_pkg::OP_NOP;
			end
			tcns_pkg::FUNC_START: begin
				q_cmd.op = (ch_ok && (cnt != '0)) ? tcns_pkg::OP_START : tcns_pkg::OP_NOP;
			end
			tcns_pkg::FUNC_STOP: begin
				q_cmd.op = ch_ok ? tcns_pkg::OP_STOP : tcns_pkg::OP_NOP;
			end
		endcase
	end

endmodule

>>> hdl/tcns_queue.sv
// Command queue that decouples the front end from the back end.
module tcns_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcns_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output tcns_pkg::cmd_t head_cmd
);

	tcns_pkg::cmd_t                mem_q [tcns_pkg::QUEUE_DEPTH];
	logic [tcns_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [tcns_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [tcns_pkg::QCNT_W-1:0]   count_q;

	assign full      = (count_q == tcns_pkg::QCNT_W'(tcns_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/tcns_back.sv
// Back end: executes commands on channel state and table RAMs, drives results.
`include "two_channel_note_sequencer_unit_macros.svh"

module tcns_back #(
	parameter int TABLE_DEPTH  = tcns_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_CHANNELS = tcns_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tcns_pkg::NOTE_W-1:0]   cfg_wr_data,
	input  logic                          q_valid,
	input  tcns_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tcns_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	typedef enum logic {
		S_EXEC,
		S_LOAD
	} state_t;

	state_t state_q;

	// Channel state
	logic                          active_q [NUM_CHANNELS];
	logic [IDX_W-1:0]              pos_q    [NUM_CHANNELS];
	logic [tcns_pkg::COUNT_W-1:0]  len_q    [NUM_CHANNELS];
	logic                          loop_q   [NUM_CHANNELS];
	logic [tcns_pkg::DUR_W-1:0]    rem_q    [NUM_CHANNELS];
	logic [tcns_pkg::NOTE_W-1:0]   tone_q   [NUM_CHANNELS];
	logic                          silent_q [NUM_CHANNELS];
	logic                          chg_q    [NUM_CHANNELS];
	logic                          load_q   [NUM_CHANNELS];
	logic [tcns_pkg::NOTE_W-1:0]   rest_q;
	logic                          m_tvalid_q;
	logic [tcns_pkg::M_DATA_W-1:0] m_tdata_q;

	// Next-state values from the execute step
	logic                          active_d [NUM_CHANNELS];
	logic [IDX_W-1:0]              pos_d    [NUM_CHANNELS];
	logic [tcns_pkg::COUNT_W-1:0]  len_d    [NUM_CHANNELS];
	logic                          loop_d   [NUM_CHANNELS];
	logic [tcns_pkg::DUR_W-1:0]    rem_d    [NUM_CHANNELS];
	logic [tcns_pkg::NOTE_W-1:0]   tone_d   [NUM_CHANNELS];
	logic                          silent_d [NUM_CHANNELS];
	logic                          chg_d    [NUM_CHANNELS];
	logic                          load_d   [NUM_CHANNELS];

	// Table access and final channel view
	logic                          ram_we   [NUM_CHANNELS];
	logic                          ram_re   [NUM_CHANNELS];
	logic [tcns_pkg::ENTRY_W-1:0]  ram_rd   [NUM_CHANNELS];
	logic [tcns_pkg::NOTE_W-1:0]   fin_tone   [NUM_CHANNELS];
	logic                          fin_silent [NUM_CHANNELS];
	logic [31:0]                   idx_ext;
	logic [IDX_W-1:0]              waddr;
	logic                          out_free;
	tcns_pkg::rpt_t                rpt [2];

	assign q_pop    = (state_q == S_EXEC) && q_valid;
	assign out_free = !m_tvalid_q || m_tready;
	assign idx_ext  = 32'(q_cmd.idx);
	assign waddr    = idx_ext[IDX_W-1:0];

	// Execute step: update timers, positions and flags, pick entries to load
	always_comb begin
		logic [tcns_pkg::DUR_W-1:0] rem_dec;
		logic [31:0]                nxt;
		logic                       hit;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			active_d[c] = active_q[c];
			pos_d[c]    = pos_q[c];
			len_d[c]    = len_q[c];
			loop_d[c]   = loop_q[c];
			rem_d[c]    = rem_q[c];
			tone_d[c]   = tone_q[c];
			silent_d[c] = silent_q[c];
			chg_d[c]    = 1'b0;
			load_d[c]   = 1'b0;
			rem_dec     = (rem_q[c] != '0) ? rem_q[c] - 1'b1 : '0;
			nxt         = 32'(pos_q[c]) + 32'd1;
			hit         = (int'(q_cmd.ch) == c);
			unique case (q_cmd.op)
				tcns_pkg::OP_TICK: begin
					if (active_q[c]) begin
						rem_d[c] = rem_dec;
						if (rem_dec == '0) begin
							chg_d[c] = 1'b1;
							if (nxt >= 32'(len_q[c])) begin
								if (!loop_q[c]) begin
									active_d[c] = 1'b0;
									pos_d[c]    = '0;
									len_d[c]    = '0;
									loop_d[c]   = 1'b0;
									tone_d[c]   = '0;
									silent_d[c] = 1'b1;
								end else begin
									pos_d[c]  = '0;
									load_d[c] = 1'b1;
								end
							end else begin
								pos_d[c]  = nxt[IDX_W-1:0];
								load_d[c] = 1'b1;
							end
						end
					end
				end
				tcns_pkg::OP_START: begin
					if (hit) begin
						active_d[c] = 1'b1;
						len_d[c]    = q_cmd.cnt;
						loop_d[c]   = q_cmd.loop_en;
						pos_d[c]    = '0;
						chg_d[c]    = 1'b1;
						load_d[c]   = 1'b1;
					end
				end
				tcns_pkg::OP_STOP: begin
					if (hit) begin
						active_d[c] = 1'b0;
						pos_d[c]    = '0;
						len_d[c]    = '0;
						loop_d[c]   = 1'b0;
						rem_d[c]    = '0;
						tone_d[c]   = '0;
						silent_d[c] = 1'b1;
						chg_d[c]    = 1'b1;
					end
				end
				tcns_pkg::OP_WRITE, tcns_pkg::OP_NOP: begin
				end
				default: begin
				end
			endcase
			ram_we[c] = q_pop && (q_cmd.op == tcns_pkg::OP_WRITE) && hit;
			ram_re[c] = q_pop && load_d[c];
		end
	end

	// One note/duration table per channel
	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_table
		tcns_ram #(
			.WIDTH(tcns_pkg::ENTRY_W),
			.DEPTH(TABLE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(waddr),
			.wdata({q_cmd.note, q_cmd.dur}),
			.re   (ram_re[g]),
			.raddr(pos_d[g]),
			.rdata(ram_rd[g])
		);
	end

	// Load step: map the fetched note onto tone and silence
	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (load_q[c]) begin
				fin_silent[c] = (ram_rd[c][tcns_pkg::ENTRY_W-1:tcns_pkg::DUR_W] == rest_q);
				fin_tone[c]   = fin_silent[c] ? '0 : ram_rd[c][tcns_pkg::ENTRY_W-1:tcns_pkg::DUR_W];
			end else begin
				fin_silent[c] = silent_q[c];
				fin_tone[c]   = tone_q[c];
			end
		end
	end

	// Per-channel reports; a missing channel reads as idle and silent
	for (genvar k = 0; k < 2; k++) begin : g_rpt
		if (k < NUM_CHANNELS) begin : g_real
			assign rpt[k] = '{busy: active_q[k], changed: chg_q[k],
				silent: fin_silent[k], tone: fin_tone[k]};
		end else begin : g_missing
			assign rpt[k] = '{busy: 1'b0, changed: 1'b0, silent: 1'b1, tone: '0};
		end
	end

	// Sequencer state, channel state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_EXEC;
			rest_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				active_q[c] <= 1'b0;
				pos_q[c]    <= '0;
				len_q[c]    <= '0;
				loop_q[c]   <= 1'b0;
				rem_q[c]    <= '0;
				tone_q[c]   <= '0;
				silent_q[c] <= 1'b1;
				chg_q[c]    <= 1'b0;
				load_q[c]   <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				rest_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_EXEC: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
					if (q_pop) begin
						for (int c = 0; c < NUM_CHANNELS; c++) begin
							active_q[c] <= active_d[c];
							pos_q[c]    <= pos_d[c];
							len_q[c]    <= len_d[c];
							loop_q[c]   <= loop_d[c];
							rem_q[c]    <= rem_d[c];
							tone_q[c]   <= tone_d[c];
							silent_q[c] <= silent_d[c];
							chg_q[c]    <= chg_d[c];
							load_q[c]   <= load_d[c];
						end
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (out_free) begin
						for (int c = 0; c < NUM_CHANNELS; c++) begin
							if (load_q[c]) begin
								rem_q[c] <= ram_rd[c][tcns_pkg::DUR_W-1:0];
							end
							tone_q[c]   <= fin_tone[c];
							silent_q[c] <= fin_silent[c];
							load_q[c]   <= 1'b0;
						end
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, rpt[1], rpt[0]};
						state_q    <= S_EXEC;
					end
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks on the execute/load sequence
	`TCNS_ASSERT_IMP(a_no_pop_in_load, state_q == S_LOAD, !q_pop)
	`TCNS_ASSERT_NXT(a_pop_enters_load, q_pop, state_q == S_LOAD)
	`TCNS_ASSERT_IMP(a_load_only_active, (state_q == S_LOAD) && load_q[0], active_q[0] && chg_q[0])
	`TCNS_ASSERT_IMP(a_result_from_load, $rose(m_tvalid_q), $past(state_q == S_LOAD))

endmodule

>>> hdl/two_channel_note_sequencer_unit.sv
// Top level of the two-channel note sequencer.
//
// Input stream (s_*): one transaction per command. s_tuser holds the function (tick,
// table write, start, stop); s_tdata holds channel, entry index, note, duration, entry
// count and loop flag. Output stream (m_*): one transaction per accepted input,
// reporting tone, silence, change and busy for both channels. cfg_wr_en/cfg_wr_data
// load the rest code; the user writes it only while the block idles (not enforced).
//
// A result passes through the command queue, the back end's execute step and its
// load step, which takes the registered read of the per-channel note/duration RAM;
// the back end pops no new command until the current one has left its load step.
// A four-entry command queue keeps s_tready high while the back end works or
// while a result waits on m_tready; s_tready drops only when that queue fills.
// A stalled result holds m_tdata and blocks the back end at its load step, not the input side.
//
// Reset: all channels idle and silent with tone zero, rest code zero. Table
// contents are undefined until written; there is no clearing pass.
module two_channel_note_sequencer_unit #(
	parameter int TABLE_DEPTH  = tcns_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_CHANNELS = tcns_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tcns_pkg::NOTE_W-1:0]   cfg_wr_data,   // rest_code
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// channel[0], entry_index[6:1], note_code[22:7], duration_ticks[38:23],
	// entry_count[45:39], loop_enable[46], zero pad[47]
	input  logic [tcns_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [tcns_pkg::S_USER_W-1:0] s_tuser,       // func[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tone_a[15:0], silent_a[16], changed_a[17], busy_a[18], tone_b[34:19],
	// silent_b[35], changed_b[36], busy_b[37], zero pad[39:38]
	output logic [tcns_pkg::M_DATA_W-1:0] m_tdata
);

	tcns_pkg::cmd_t push_cmd;
	tcns_pkg::cmd_t head_cmd;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;

	// Accept and classify
	tcns_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (push_cmd)
	);

	// Decoupling queue
	tcns_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head_cmd (head_cmd)
	);

	// Execute and report
	tcns_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_valid    (q_valid),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
